// File: rtl/core/assembly_source_tokenizer_macros.svh
// Assertion macros shared by the tokenizer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSEMBLY_SOURCE_TOKENIZER_MACROS_SVH
`define ASSEMBLY_SOURCE_TOKENIZER_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked only out of reset
`define AST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define AST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define AST_ASSERT(lbl, prop, msg)
`define AST_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/core/ast_pkg.sv
// Shared types, token kinds and the mnemonic table of the tokenizer.
// No dependencies.
package ast_pkg;

    typedef logic [2:0] t_kind;

    localparam t_kind K_NUMBER      = 3'd0;
    localparam t_kind K_ADDRESS     = 3'd1;
    localparam t_kind K_IDENT       = 3'd2;
    localparam t_kind K_MNEMONIC    = 3'd3;
    localparam t_kind K_UNEXPECTED  = 3'd4;
    localparam t_kind K_END         = 3'd5;
    localparam t_kind K_BRACKET_ERR = 3'd6;

    localparam int QUEUE_DEPTH = 4;
    localparam int MNEM_COUNT  = 15;

    // token as it travels from front to back; mnemonic still unresolved
    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [7:0]  length;
        logic [31:0] chars;     // first four characters, first in low byte
        logic        is_short;  // four characters or fewer
        logic        is_last;
    } t_token;

    // up to two tokens per transaction, t0 first
    typedef struct packed {
        logic   v0;
        logic   v1;
        t_token t0;
        t_token t1;
    } t_push;

    typedef struct packed {
        logic       hit;
        logic [3:0] code;
    } t_match;

    // strings are reversed so that the first character lands in the low byte
    localparam logic [31:0] MNEM_CHARS [MNEM_COUNT] = '{
        {8'h00, "VOM"}, {8'h00, "DNA"}, {16'h0000, "RO"}, "DNAN",
        {8'h00, "RON"}, {8'h00, "DDA"}, {8'h00, "BUS"},   {8'h00, "PMJ"},
        {8'h00, "QEJ"}, {8'h00, "ELJ"}, "QELJ",           {8'h00, "PON"},
        "QENJ",         {8'h00, "RGJ"}, "QEGJ"
    };
    localparam logic [7:0] MNEM_LEN [MNEM_COUNT] = '{
        8'd3, 8'd3, 8'd2, 8'd4, 8'd3, 8'd3, 8'd3, 8'd3,
        8'd3, 8'd3, 8'd4, 8'd3, 8'd4, 8'd3, 8'd4
    };

    function automatic t_match mnem_lookup(input logic [31:0] chars, input logic [7:0] len);
        t_match m;
        m = '0;
        for (int i = MNEM_COUNT - 1; i >= 0; i--) begin
            if (MNEM_CHARS[i] == chars && MNEM_LEN[i] == len) begin
                m.hit  = 1'b1;
                m.code = 4'(i);
            end
        end
        return m;
    endfunction

endpackage

// File: rtl/core/ast_front.sv
// Front end: character classification and scan state, up to two tokens per transaction.
// Depends on ast_pkg and assembly_source_tokenizer_macros.svh.
`include "assembly_source_tokenizer_macros.svh"
module ast_front #(
    parameter int POSITION_BITS    = 16,
    parameter int MAX_TOKEN_LENGTH = 255
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_action,
    input  logic [7:0]    i_char_code,
    output ast_pkg::t_push o_push
);
    import ast_pkg::*;

    localparam int LW = $clog2(MAX_TOKEN_LENGTH + 1);
    localparam logic [LW-1:0] LenMax = LW'(MAX_TOKEN_LENGTH);

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_COMMENT = 3'd1;
    localparam logic [2:0] MODE_NUMBER  = 3'd2;
    localparam logic [2:0] MODE_IDENT   = 3'd3;
    localparam logic [2:0] MODE_ADDR    = 3'd4;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    logic [2:0]               r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [LW-1:0]            r_len, n_len;
    logic [31:0]              r_chars, n_chars;

    logic [LW-1:0]  grown;
    logic           c_space, c_digit, c_alpha;
    logic           use_idle;
    logic           pend_v, sec_v;
    t_kind          pend_kind, sec_kind;
    logic [7:0]     sec_len;
    logic [LW+7:0]  len_ext;
    logic [POSITION_BITS+15:0] start_ext, pos_ext;
    t_token         pend_tok, sec_tok;

    always_comb begin
        c_space = (i_char_code inside {[8'd9:8'd13]}) || i_char_code == 8'd32;
        c_digit = i_char_code inside {[8'd48:8'd57]};
        c_alpha = (i_char_code inside {[8'd97:8'd122]}) || (i_char_code inside {[8'd65:8'd90]})
                  || i_char_code == 8'd95;
        grown   = (r_len < LenMax) ? r_len + LW'(1) : r_len;

        n_mode    = r_mode;
        n_pos     = r_pos;
        n_start   = r_start;
        n_len     = r_len;
        n_chars   = r_chars;
        use_idle  = 1'b0;
        pend_v    = 1'b0;
        pend_kind = K_NUMBER;
        sec_v     = 1'b0;
        sec_kind  = K_UNEXPECTED;
        sec_len   = 8'd1;

        if (i_accept) begin
            if (i_action) begin
                case (r_mode)
                    MODE_NUMBER: begin
                        pend_v    = 1'b1;
                        pend_kind = K_NUMBER;
                    end
                    MODE_IDENT: begin
                        pend_v    = 1'b1;
                        pend_kind = K_IDENT;
                    end
                    MODE_ADDR: begin
                        pend_v    = 1'b1;
                        pend_kind = K_BRACKET_ERR;
                    end
                    default: ;
                endcase
                sec_v    = 1'b1;
                sec_kind = K_END;
                sec_len  = 8'd0;
                n_mode   = MODE_IDLE;
            end else begin
                n_pos = r_pos + POSITION_BITS'(1);
                case (r_mode)
                    MODE_COMMENT: begin
                        if (i_char_code == CH_LF) n_mode = MODE_IDLE;
                    end
                    MODE_NUMBER: begin
                        if (c_digit) begin
                            n_len = grown;
                        end else begin
                            pend_v    = 1'b1;
                            pend_kind = K_NUMBER;
                            use_idle  = 1'b1;
                        end
                    end
                    MODE_IDENT: begin
                        if (c_alpha || c_digit) begin
                            if (r_len < LW'(4)) n_chars[{r_len[1:0], 3'b000} +: 8] = i_char_code;
                            n_len = grown;
                        end else begin
                            pend_v    = 1'b1;
                            pend_kind = K_IDENT;
                            use_idle  = 1'b1;
                        end
                    end
                    MODE_ADDR: begin
                        if (c_digit) begin
                            n_len = grown;
                        end else begin
                            // a stray character inside brackets is dropped
                            pend_v    = 1'b1;
                            pend_kind = (i_char_code == CH_RBRACK) ? K_ADDRESS : K_BRACKET_ERR;
                            n_mode    = MODE_IDLE;
                        end
                    end
                    default: use_idle = 1'b1;
                endcase

                if (use_idle) begin
                    if (c_space || i_char_code == CH_COMMA) begin
                        n_mode = MODE_IDLE;
                    end else if (i_char_code == CH_HASH) begin
                        n_mode = MODE_COMMENT;
                    end else if (c_digit) begin
                        n_mode  = MODE_NUMBER;
                        n_start = r_pos;
                        n_len   = LW'(1);
                    end else if (i_char_code == CH_LBRACK) begin
                        n_mode  = MODE_ADDR;
                        n_start = r_pos + POSITION_BITS'(1);
                        n_len   = '0;
                    end else if (c_alpha) begin
                        n_mode  = MODE_IDENT;
                        n_start = r_pos;
                        n_len   = LW'(1);
                        n_chars = {24'd0, i_char_code};
                    end else begin
                        n_mode = MODE_IDLE;
                        sec_v  = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        len_ext   = {8'd0, r_len};
        start_ext = {16'd0, r_start};
        pos_ext   = {16'd0, r_pos};

        pend_tok.kind     = pend_kind;
        pend_tok.start    = start_ext[15:0];
        pend_tok.length   = len_ext[7:0];
        pend_tok.chars    = r_chars;
        pend_tok.is_short = (r_len <= LW'(4));
        pend_tok.is_last  = !sec_v;

        sec_tok.kind     = sec_kind;
        sec_tok.start    = pos_ext[15:0];
        sec_tok.length   = sec_len;
        sec_tok.chars    = '0;
        sec_tok.is_short = 1'b0;
        sec_tok.is_last  = 1'b1;

        o_push.v0 = pend_v || sec_v;
        o_push.v1 = pend_v && sec_v;
        o_push.t0 = pend_v ? pend_tok : sec_tok;
        o_push.t1 = sec_tok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_chars <= '0;
        end else begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
            r_chars <= n_chars;
        end
    end

    `AST_ASSERT(a_end_idles, (i_accept && i_action) |=> (r_mode == MODE_IDLE), "mode not idle after end of text")
    `AST_ASSERT(a_end_keeps_pos, (i_accept && i_action) |=> (r_pos == $past(r_pos)), "end of text moved position")

endmodule

// File: rtl/core/ast_queue.sv
// Token queue between front and back: up to two writes and one read per cycle.
// Depends on ast_pkg and assembly_source_tokenizer_macros.svh.
`include "assembly_source_tokenizer_macros.svh"
module ast_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ast_pkg::t_push  i_push,
    input  logic            i_pop,
    output ast_pkg::t_token o_head,
    output logic            o_head_valid,
    output logic            o_almost_full
);
    import ast_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_token          r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   push_n;
    logic [PW-1:0]   wr_next;

    always_comb begin
        push_n        = CW'(i_push.v0) + CW'(i_push.v1);
        wr_next       = r_wr + PW'(1);
        o_head        = r_mem[r_rd];
        o_head_valid  = (r_count != '0);
        // two free entries are needed for the worst transaction
        o_almost_full = (r_count > CW'(QUEUE_DEPTH - 2));
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) r_mem[r_wr] <= i_push.t0;
        if (i_push.v1) r_mem[wr_next] <= i_push.t1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PW'(push_n);
            r_rd    <= r_rd + PW'(i_pop);
            r_count <= r_count + push_n - CW'(i_pop);
        end
    end

    `AST_ASSERT(a_no_overflow, push_n <= (CW'(QUEUE_DEPTH) - r_count), "queue overflow")
    `AST_ASSERT(a_no_underflow, !(i_pop && r_count == '0), "pop from empty queue")

endmodule

// File: rtl/core/ast_back.sv
// Back end: mnemonic resolution and the output register.
// Depends on ast_pkg and assembly_source_tokenizer_macros.svh.
`include "assembly_source_tokenizer_macros.svh"
module ast_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ast_pkg::t_token i_head,
    input  logic            i_head_valid,
    output logic            o_pop,
    input  logic            i_stall,
    output logic            o_valid,
    output logic [2:0]      o_token_kind,
    output logic [15:0]     o_token_start,
    output logic [7:0]      o_token_length,
    output logic [3:0]      o_mnemonic_code,
    output logic            o_is_last
);
    import ast_pkg::*;

    logic        r_valid;
    t_kind       r_kind, n_kind;
    logic [15:0] r_start;
    logic [7:0]  r_length;
    logic [3:0]  r_code, n_code;
    logic        r_last;
    t_match      match;

    always_comb begin
        o_pop  = i_head_valid && (!r_valid || !i_stall);
        match  = mnem_lookup(i_head.chars, i_head.length);
        n_kind = i_head.kind;
        n_code = 4'd0;
        if (i_head.kind == K_IDENT && i_head.is_short && match.hit) begin
            n_kind = K_MNEMONIC;
            n_code = match.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= i_head_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind   <= n_kind;
            r_start  <= i_head.start;
            r_length <= i_head.length;
            r_code   <= n_code;
            r_last   <= i_head.is_last;
        end
    end

    assign o_valid         = r_valid;
    assign o_token_kind    = r_kind;
    assign o_token_start   = r_start;
    assign o_token_length  = r_length;
    assign o_mnemonic_code = r_code;
    assign o_is_last       = r_last;

    `AST_ASSERT(a_pop_shows, o_pop |=> r_valid, "popped token not presented")
    `AST_ASSERT(a_code_kind, r_valid |-> (r_kind == K_MNEMONIC || r_code == 4'd0), "code on non-mnemonic")
    `AST_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !r_valid, "output valid after reset")

endmodule

// File: rtl/core/assembly_source_tokenizer.sv
// Assembly source tokenizer top level: front end, token queue, back end.
// Depends on ast_pkg, ast_front, ast_queue, ast_back.
//
// Usage:
//   Input channel (i_valid / o_stall): one transaction per cycle while o_stall
//   is low, each a source character (i_action = 0) or end of text (i_action = 1).
//   Output channel (o_valid / i_stall): up to two tokens per transaction, with
//   kind, start offset, length, mnemonic code and o_is_last marking the
//   final token caused by an input transaction.
//   The front end classifies each character combinationally and may give up
//   to two tokens, written into the queue; the back end moves the queue head
//   into the output register and presents one token a cycle while i_stall is
//   low, so sustained input is one character per cycle while the tokens keep up.
//   A four-entry queue sits between the two ends; o_stall rises when fewer
//   than two entries are free.
//   Receiver stall: the output register holds its token, the queue fills and
//   then the input stalls; nothing is lost.
//   Reset (synchronous, active low) clears the scan state and the position
//   to zero, empties the queue and drops o_valid.
module assembly_source_tokenizer #(
    parameter int POSITION_BITS    = 16,
    parameter int MAX_TOKEN_LENGTH = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [7:0]  i_char_code,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_token_kind,
    output logic [15:0] o_token_start,
    output logic [7:0]  o_token_length,
    output logic [3:0]  o_mnemonic_code,
    output logic        o_is_last
);
    import ast_pkg::*;

    t_push  push;
    t_token head;
    logic   head_valid;
    logic   pop;
    logic   almost_full;
    logic   accept;

    assign o_stall = almost_full;
    assign accept  = i_valid && !almost_full;

    ast_front #(
        .POSITION_BITS   (POSITION_BITS),
        .MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_action   (i_action),
        .i_char_code(i_char_code),
        .o_push     (push)
    );

    ast_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_almost_full(almost_full)
    );

    ast_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_head_valid   (head_valid),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_mnemonic_code(o_mnemonic_code),
        .o_is_last      (o_is_last)
    );

endmodule
